// ===== hw/rtl/itda_pkg.sv =====
// itda_pkg: shared constants and types for the integer to decimal ascii block
// no dependencies; imported by int_to_decimal_ascii_core

package itda_pkg;

  localparam int VALUE_BITS   = 32;
  // decimal digits needed for VALUE_BITS bits, log10(2) approximated by 1233/4096
  localparam int DIGITS       = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_BITS     = DIGITS * 4;
  localparam int BIT_CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DIG_CNT_BITS = $clog2(DIGITS + 1);
  localparam int CHAR_BITS    = 6;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = CHAR_BITS'(45);
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = CHAR_BITS'(57);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } itda_state_t;

endpackage

// ===== hw/rtl/int_to_decimal_ascii_core.sv =====
// int_to_decimal_ascii_core: signed integer to decimal ascii text, bit-serial
// depends on itda_pkg (widths, character codes, state type)
//
// usage
//   input channel: in_value with in_valid / in_stall; one item is taken when
//   in_valid is high and in_stall is low. in_stall stays high from the
//   accepting edge until the last character of that item has been loaded
//   into the output register.
//   output channel: out_char_code / out_last with out_valid / out_stall; one
//   character per item, most significant first, a leading minus for negative
//   values, no leading zeros, out_last on the final character.
//   timing: the magnitude is shifted into a bcd register one bit per cycle
//   (double dabble), then a minus sign is loaded for a negative value, leading
//   zero digits are dropped one per cycle and the characters leave one per
//   cycle through the output register while the receiver does not stall;
//   a new item is taken only after its last character has been loaded.
//   stall: a held output item keeps its value; the sequencer waits until the
//   output register frees up, so nothing is lost.
//   reset: rst_n low on a clock edge empties the output register and returns
//   the sequencer to idle; no other state survives between items.

module int_to_decimal_ascii_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [itda_pkg::VALUE_BITS-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [itda_pkg::CHAR_BITS-1:0] out_char_code,
  output logic                                 out_last
);
  import itda_pkg::*;

  itda_state_t               state_r, state_nxt;
  logic [VALUE_BITS-1:0]     mag_r, mag_nxt;
  logic [BCD_BITS-1:0]       bcd_r, bcd_nxt;
  logic [BIT_CNT_BITS-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_BITS-1:0]   dig_left_r, dig_left_nxt;
  logic                      neg_r, neg_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0]      out_char_r, out_char_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0]     in_raw;
  logic [VALUE_BITS-1:0]     in_mag;
  logic [BCD_BITS-1:0]       bcd_adj;
  logic [3:0]                top_digit;
  logic                      slot_free;

  assign in_raw    = $unsigned(in_value);
  assign in_mag    = in_raw[VALUE_BITS-1] ? (~in_raw + VALUE_BITS'(1)) : in_raw;
  assign top_digit = bcd_r[BCD_BITS-1 -: 4];
  assign slot_free = !out_valid_r || !out_stall;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_left_r <= dig_left_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_left_nxt  = dig_left_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    in_stall      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mag_nxt      = in_mag;
          neg_nxt      = in_raw[VALUE_BITS-1];
          bcd_nxt      = '0;
          bit_cnt_nxt  = '0;
          dig_left_nxt = DIG_CNT_BITS'(DIGITS);
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_BITS-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_BITS'(1);
        if (bit_cnt_r == BIT_CNT_BITS'(VALUE_BITS - 1)) begin
          state_nxt = neg_r ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == 4'd0 && dig_left_r > DIG_CNT_BITS'(1)) begin
          bcd_nxt      = {bcd_r[BCD_BITS-5:0], 4'd0};
          dig_left_nxt = dig_left_r - DIG_CNT_BITS'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {{(CHAR_BITS-4){1'b0}}, top_digit};
          out_last_nxt  = (dig_left_r == DIG_CNT_BITS'(1));
          bcd_nxt       = {bcd_r[BCD_BITS-5:0], 4'd0};
          dig_left_nxt  = dig_left_r - DIG_CNT_BITS'(1);
          if (dig_left_r == DIG_CNT_BITS'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CONV && bit_cnt_r == '0))
    else $error("accepted item did not start conversion");

  a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> neg_r)
    else $error("minus sign for a non-negative item");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_SKIP) |-> (dig_left_r != '0))
    else $error("digit count ran out");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS ||
                     (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_NINE)))
    else $error("output character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign flagged as last");

endmodule

// ===== verif/tb_int_to_decimal_ascii_core.sv =====
// tb_int_to_decimal_ascii_core: random and directed test of the integer to decimal ascii block
// a self-checking predictor compares every output character with the expected text
// depends on itda_pkg and int_to_decimal_ascii_core

module tb_int_to_decimal_ascii_core;
  import itda_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_CHAR   = 120;
  localparam int RANDOM_ITEMS   = 130;
  localparam int SETTLE_CYCLES  = 60;
  localparam int MAX_REPORTS    = 50;
  localparam longint MIN32      = -64'sd2147483648;

  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 last;
  } text_char_t;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [CHAR_BITS-1:0]        out_char_code;
  logic                        out_last;

  logic [VALUE_BITS-1:0] pending_values[$];
  text_char_t            expected_text[$];

  int errors           = 0;
  int numbers_taken    = 0;
  int negatives_taken  = 0;
  int chars_seen       = 0;
  int idle_cycles      = 0;
  int send_gap         = 0;
  int stall_left       = 0;
  int hold_left        = 0;
  int in_stall_run     = 0;
  int longest_in_stall = 0;
  bit hold_done        = 1'b0;
  bit in_calm          = 1'b0;
  bit out_calm         = 1'b0;

  int_to_decimal_ascii_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch at char %0d: %s", chars_seen, what);
  endtask

  // expected decimal text of one number, most significant character first
  function automatic void predict_text(logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS:0] mag;
    logic [3:0]          dec [0:23];
    int                  ndig;
    logic                neg;
    text_char_t          c;
    neg  = v[VALUE_BITS-1];
    mag  = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    ndig = 0;
    do begin
      dec[ndig] = 4'(mag % 10);
      mag       = mag / 10;
      ndig++;
    end while (mag != 0);
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      c.code = CHAR_ZERO + CHAR_BITS'(dec[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    longint m;
    int     k;
    k = 0;
    case ($urandom_range(0, 3))
      0: m = $urandom;
      1: begin
        m = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) m = -m;
      end
      2: begin
        // around a power of ten
        m = 1;
        repeat ($urandom_range(0, 9)) m = m * 10;
        k = $urandom_range(0, 2);
        m = m + k - 1;
        if ($urandom_range(0, 1)) m = -m;
      end
      default: begin
        k = $urandom_range(0, 40);
        m = k - 20;
      end
    endcase
    return VALUE_BITS'(m);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_text(in_value);
        numbers_taken++;
        if (in_value < 0) negatives_taken++;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
      end
      if (in_valid && in_stall) begin
        in_stall_run++;
        if (in_stall_run > longest_in_stall) longest_in_stall = in_stall_run;
      end else begin
        in_stall_run = 0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_values.size() > 0) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
          send_gap = idle_len(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    text_char_t want;
    int         n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d last %0b", out_char_code, out_last));
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code)
            report_mismatch($sformatf("char_code %0d, expected %0d", out_char_code, want.code));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
        end
        if (!hold_done && chars_seen >= HOLD_AT_CHAR) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        n = idle_len(out_calm);
        out_stall <= (n > 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without progress", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    static longint directed[] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345,
      999999999, -999999999, 1000000000, -1000000000,
      1234567890, -1234567890, 2147483647, -2147483647, MIN32,
      1431655765, -1431655766, 2147483640
    };
    foreach (directed[i]) pending_values.push_back(VALUE_BITS'(directed[i]));
    repeat (RANDOM_ITEMS) pending_values.push_back(random_value());
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_values.size() > 0 || in_valid) @(posedge clk);
    while (expected_text.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("converted %0d numbers (%0d negative) into %0d characters",
             numbers_taken, negatives_taken, chars_seen);
    $display("longest input back-pressure: %0d cycles", longest_in_stall);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
